// File: src/sm83_pkg.sv
// Shared types and constants of the SM83 subset executor.
package sm83_pkg;

  localparam int unsigned AddrBits = 16;

  typedef enum logic [1:0] {
    ACT_PRELOAD = 2'd0,
    ACT_EXEC    = 2'd1,
    ACT_SETPC   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [AddrBits-1:0]   address;
    logic [7:0]            data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] prog_counter;
    logic [15:0] stack_ptr;
    logic [7:0]  accum;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [3:0]  flag_bits;
    logic [4:0]  cycles_taken;
    logic [31:0] total_cycles;
    logic        irq_enable;
    logic        halted_unknown;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_IMM1,
    ST_IMM2,
    ST_RDDATA,
    ST_WR2,
    ST_DONE
  } exec_state_e;

  localparam logic [15:0] HighPage = 16'hff00;
  localparam logic [3:0]  FlagZ = 4'h8;
  localparam logic [3:0]  FlagN = 4'h4;
  localparam logic [3:0]  FlagH = 4'h2;
  localparam logic [3:0]  FlagC = 4'h1;

  // Instruction length in bytes.
  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] l;
    l = 2'd1;
    case (op)
      8'h01, 8'h08, 8'h11, 8'h21, 8'h31, 8'hc3, 8'hea: l = 2'd3;
      8'h06, 8'h0e, 8'h10, 8'h16, 8'h1e, 8'h20, 8'h36, 8'h3e, 8'he0, 8'hf0,
      8'hfe: l = 2'd2;
      default: l = 2'd1;
    endcase
    return l;
  endfunction

  function automatic logic op_known(input logic [7:0] op);
    logic k;
    k = 1'b0;
    if (op <= 8'h17) k = 1'b1;
    case (op)
      8'h1e, 8'h20, 8'h21, 8'h22, 8'h31, 8'h32, 8'h36, 8'h3e, 8'haf, 8'hc3,
      8'he0, 8'hea, 8'hf0, 8'hf3, 8'hfe: k = 1'b1;
      default: ;
    endcase
    return k;
  endfunction

endpackage

// File: src/sm83_subset_instruction_executor.sv
// Top level of the SM83 subset executor: command queue and execution engine.
// Preload and set-PC transactions are handled in the idle state of the execution engine.
// An execute is sequenced around the single-port memory: an issue in the idle state,
// the opcode, up to two immediates and one data byte or a second store, then a result state.
// The result register is shown with empty low on the cycle after completion.
// Reset clears registers to zero, sets the interrupt enable; memory is undefined.
module sm83_subset_instruction_executor import sm83_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] prog_counter_o,
  output logic [15:0] stack_ptr_o,
  output logic [7:0]  accum_o,
  output logic [15:0] pair_bc_o,
  output logic [15:0] pair_de_o,
  output logic [15:0] pair_hl_o,
  output logic [3:0]  flag_bits_o,
  output logic [4:0]  cycles_taken_o,
  output logic [31:0] total_cycles_o,
  output logic        irq_enable_o,
  output logic        halted_unknown_o
);

  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  sm83_front u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .address_i, .data_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  sm83_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop)
  );

  assign empty = !res_valid;
  assign prog_counter_o   = res.prog_counter;
  assign stack_ptr_o      = res.stack_ptr;
  assign accum_o          = res.accum;
  assign pair_bc_o        = res.pair_bc;
  assign pair_de_o        = res.pair_de;
  assign pair_hl_o        = res.pair_hl;
  assign flag_bits_o      = res.flag_bits;
  assign cycles_taken_o   = res.cycles_taken;
  assign total_cycles_o   = res.total_cycles;
  assign irq_enable_o     = res.irq_enable;
  assign halted_unknown_o = res.halted_unknown;

  a_stop_zero_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && halted_unknown_o) |-> (cycles_taken_o == 5'd0))
    else $error("stopped result reports cycles");

  a_cycles_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cycles_taken_o <= 5'd20))
    else $error("cycle count out of range");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(!empty) && $past(rst_ni)) |-> (total_cycles_o >= {27'd0, cycles_taken_o}
      || total_cycles_o < 32'd20))
    else $error("running total inconsistent");

endmodule

// File: src/sm83_front.sv
// Input stage and command queue that decouples accepting from executing.
module sm83_front import sm83_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action_i,
  input  logic [AddrBits-1:0] address_i,
  input  logic [7:0]          data_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_take_i
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrBits = $clog2(Depth);

  cmd_t                 queue_q [Depth];
  logic [PtrBits-1:0]   wptr_q, rptr_q;
  logic [PtrBits:0]     count_q, count_d;
  logic                 wr_en, rd_en;

  assign full = (count_q == (PtrBits+1)'(Depth));
  // Undefined actions are dropped here and never reach the back end.
  assign wr_en = push && !full && (action_i != ACT_NONE);
  assign cmd_valid_o = (count_q != '0);
  assign rd_en = cmd_take_i && cmd_valid_o;
  assign cmd_o = queue_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) count_d = count_q + 1'b1;
    else if (!wr_en && rd_en) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (wr_en) wptr_q <= wptr_q + 1'b1;
      if (rd_en) rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) queue_q[wptr_q] <= '{action: action_e'(action_i), address: address_i,
                                    data: data_i};
  end

endmodule

// File: src/sm83_back.sv
// Execution engine: register file, byte memory and instruction sequencer.
module sm83_back import sm83_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_take_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_take_i
);

  logic [7:0] mem_q [2**AddrBits];
  logic [7:0] rdata_q;

  logic [15:0] pc_q, pc_d, sp_q, sp_d, bc_q, bc_d, de_q, de_d, hl_q, hl_d;
  logic [7:0]  a_q, a_d, op_q, op_d, i1_q, i1_d, i2_q, i2_d;
  logic [3:0]  f_q, f_d;
  logic        ime_q, ime_d, stop_q, stop_d;
  logic [31:0] tot_q, tot_d;
  exec_state_e st_q, st_d;
  res_t        res_q, res_d;
  logic        resv_q, resv_d;

  logic [15:0] maddr;
  logic [7:0]  mwdata;
  logic        mwe;
  logic [15:0] a16;
  logic [7:0]  t, r8;
  logic [4:0]  cyc;
  logic [16:0] sum;
  logic [12:0] hsum;
  logic [1:0]  len;

  always_ff @(posedge clk_i) begin
    if (mwe) mem_q[maddr] <= mwdata;
    rdata_q <= mem_q[maddr];
  end

  assign a16 = {i2_q, i1_q};
  assign cmd_take_o = (st_q == ST_IDLE) && cmd_valid_i &&
                      !(cmd_i.action == ACT_EXEC && resv_q && !res_take_i);
  assign res_valid_o = resv_q;
  assign res_o = res_q;

  always_comb begin
    st_d = st_q; pc_d = pc_q; sp_d = sp_q; bc_d = bc_q; de_d = de_q; hl_d = hl_q;
    a_d = a_q; f_d = f_q; ime_d = ime_q; stop_d = stop_q; tot_d = tot_q;
    op_d = op_q; i1_d = i1_q; i2_d = i2_q;
    res_d = res_q; resv_d = resv_q && !res_take_i;
    maddr = pc_q; mwdata = a_q; mwe = 1'b0;
    t = 8'h00; r8 = 8'h00; cyc = 5'd4; sum = '0; hsum = '0;
    len = op_len(op_q);
    case (st_q)
      ST_IDLE: begin
        if (cmd_take_o) begin
          case (cmd_i.action)
            ACT_PRELOAD: begin
              maddr = cmd_i.address; mwdata = cmd_i.data; mwe = 1'b1;
            end
            ACT_SETPC: begin
              pc_d = cmd_i.address; stop_d = 1'b0;
            end
            ACT_EXEC: begin
              maddr = pc_q;
              st_d = stop_q ? ST_DONE : ST_OP;
            end
            default: ;
          endcase
        end
      end
      ST_OP: begin
        op_d = rdata_q;
        maddr = pc_q + 16'd1;
        if (!op_known(rdata_q)) st_d = ST_DONE;
        else if (op_len(rdata_q) == 2'd1) st_d = ST_DONE;
        else st_d = ST_IMM1;
        if (rdata_q == 8'h0a) begin
          maddr = bc_q; st_d = ST_RDDATA;
        end
      end
      ST_IMM1: begin
        i1_d = rdata_q;
        maddr = pc_q + 16'd2;
        if (len == 2'd3) st_d = ST_IMM2;
        else if (op_q == 8'hf0) begin
          maddr = HighPage + {8'h00, rdata_q}; st_d = ST_RDDATA;
        end else st_d = ST_DONE;
      end
      ST_IMM2: begin
        i2_d = rdata_q;
        st_d = ST_DONE;
        if (op_q == 8'h08) begin
          maddr = {rdata_q, i1_q}; mwdata = sp_q[7:0]; mwe = 1'b1; st_d = ST_WR2;
        end
      end
      ST_RDDATA: begin
        i2_d = rdata_q;
        st_d = ST_DONE;
      end
      ST_WR2: begin
        maddr = a16 + 16'd1; mwdata = sp_q[15:8]; mwe = 1'b1;
        i2_d = i2_q;
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (!resv_d) begin
          st_d = ST_IDLE;
          if (stop_q) cyc = 5'd0;
          else if (!op_known(op_q)) begin
            stop_d = 1'b1; cyc = 5'd0;
          end else begin
            pc_d = pc_q + {14'd0, len};
            case (op_q)
              8'h00, 8'h10: ;
              8'h01: begin bc_d = a16; cyc = 5'd12; end
              8'h02: begin maddr = bc_q; mwe = 1'b1; cyc = 5'd8; end
              8'h03: begin bc_d = bc_q + 16'd1; cyc = 5'd8; end
              8'h04, 8'h0c, 8'h14: begin
                t = (op_q == 8'h04) ? bc_q[15:8] : (op_q == 8'h0c) ? bc_q[7:0]
                    : de_q[15:8];
                r8 = t + 8'd1;
                f_d = (f_q & FlagC) | ((r8 == 8'h00) ? FlagZ : 4'h0)
                      | ((t[3:0] == 4'hf) ? FlagH : 4'h0);
                if (op_q == 8'h04) bc_d[15:8] = r8;
                else if (op_q == 8'h0c) bc_d[7:0] = r8;
                else de_d[15:8] = r8;
              end
              8'h05, 8'h0d, 8'h15: begin
                t = (op_q == 8'h05) ? bc_q[15:8] : (op_q == 8'h0d) ? bc_q[7:0]
                    : de_q[15:8];
                r8 = t - 8'd1;
                f_d = (f_q & FlagC) | FlagN | ((r8 == 8'h00) ? FlagZ : 4'h0)
                      | ((t[3:0] == 4'h0) ? FlagH : 4'h0);
                if (op_q == 8'h05) bc_d[15:8] = r8;
                else if (op_q == 8'h0d) bc_d[7:0] = r8;
                else de_d[15:8] = r8;
              end
              8'h06: begin bc_d[15:8] = i1_q; cyc = 5'd8; end
              8'h07: begin a_d = {a_q[6:0], a_q[7]}; f_d = {3'b000, a_q[7]}; end
              8'h08: cyc = 5'd20;
              8'h09: begin
                sum = {1'b0, hl_q} + {1'b0, bc_q};
                hsum = {1'b0, hl_q[11:0]} + {1'b0, bc_q[11:0]};
                f_d = (f_q & FlagZ) | (hsum[12] ? FlagH : 4'h0) | (sum[16] ? FlagC : 4'h0);
                hl_d = sum[15:0]; cyc = 5'd8;
              end
              8'h0a: begin a_d = i2_q; cyc = 5'd8; end
              8'h0b: begin bc_d = bc_q - 16'd1; cyc = 5'd8; end
              8'h0e: begin bc_d[7:0] = i1_q; cyc = 5'd8; end
              8'h0f: begin a_d = {a_q[0], a_q[7:1]}; f_d = {3'b000, a_q[0]}; end
              8'h11: begin de_d = a16; cyc = 5'd12; end
              8'h12: begin maddr = de_q; mwe = 1'b1; cyc = 5'd8; end
              8'h13: begin de_d = de_q + 16'd1; cyc = 5'd8; end
              8'h16: begin de_d[15:8] = i1_q; cyc = 5'd8; end
              8'h17: begin a_d = {a_q[6:0], f_q[0]}; f_d = {3'b000, a_q[7]}; end
              8'h1e: begin de_d[7:0] = i1_q; cyc = 5'd8; end
              8'h20: begin
                cyc = 5'd8;
                if (!f_q[3]) begin
                  pc_d = pc_q + 16'd2 + {{8{i1_q[7]}}, i1_q}; cyc = 5'd12;
                end
              end
              8'h21: begin hl_d = a16; cyc = 5'd12; end
              8'h22: begin maddr = hl_q; mwe = 1'b1; hl_d = hl_q + 16'd1; cyc = 5'd8; end
              8'h31: begin sp_d = a16; cyc = 5'd12; end
              8'h32: begin maddr = hl_q; mwe = 1'b1; hl_d = hl_q - 16'd1; cyc = 5'd8; end
              8'h36: begin maddr = hl_q; mwdata = i1_q; mwe = 1'b1; cyc = 5'd12; end
              8'h3e: begin a_d = i1_q; cyc = 5'd8; end
              8'haf: begin a_d = 8'h00; f_d = FlagZ; end
              8'hc3: begin pc_d = a16; cyc = 5'd16; end
              8'he0: begin
                maddr = HighPage + {8'h00, i1_q}; mwe = 1'b1; cyc = 5'd12;
              end
              8'hea: begin maddr = a16; mwe = 1'b1; cyc = 5'd16; end
              8'hf0: begin a_d = i2_q; cyc = 5'd12; end
              8'hf3: ime_d = 1'b0;
              8'hfe: begin
                f_d = FlagN | ((a_q == i1_q) ? FlagZ : 4'h0)
                      | ((a_q[3:0] < i1_q[3:0]) ? FlagH : 4'h0)
                      | ((a_q < i1_q) ? FlagC : 4'h0);
                cyc = 5'd8;
              end
              default: ;
            endcase
          end
          tot_d = tot_q + {27'd0, cyc};
          resv_d = 1'b1;
          res_d = '{prog_counter: pc_d, stack_ptr: sp_d, accum: a_d, pair_bc: bc_d,
                    pair_de: de_d, pair_hl: hl_d, flag_bits: f_d, cycles_taken: cyc,
                    total_cycles: tot_d, irq_enable: ime_d, halted_unknown: stop_d};
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pc_q <= '0; sp_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0;
      a_q <= '0; f_q <= '0; ime_q <= 1'b1; stop_q <= 1'b0; tot_q <= '0; resv_q <= 1'b0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; sp_q <= sp_d; bc_q <= bc_d; de_q <= de_d;
      hl_q <= hl_d; a_q <= a_d; f_q <= f_d; ime_q <= ime_d; stop_q <= stop_d;
      tot_q <= tot_d; resv_q <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; i1_q <= i1_d; i2_q <= i2_d; res_q <= res_d;
  end

endmodule
